// ----- rtl/core/pwm_timer_peripheral_unit_assert.svh -----
// Assertion macros shared by the timer RTL.
// Each macro exists twice: a checking form and an empty form for builds
// that leave assertions out.
`ifndef PWM_TIMER_PERIPHERAL_UNIT_ASSERT_SVH
`define PWM_TIMER_PERIPHERAL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is asserted
`define PTMR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked property that also holds during reset
`define PTMR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define PTMR_ASSERT(label, clk, rst_n, prop, msg)
`define PTMR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/core/ptmr_pkg.sv -----
`timescale 1ns / 1ps

package ptmr_pkg;

    // Item kinds carried on the input channel
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } ptmr_op_t;

    // Timer register map (input item reg_index)
    localparam logic [3:0] REG_CTRL   = 4'd0;
    localparam logic [3:0] REG_STATUS = 4'd1;
    localparam logic [3:0] REG_EVENT  = 4'd2;
    localparam logic [3:0] REG_MODE12 = 4'd3;
    localparam logic [3:0] REG_MODE34 = 4'd4;
    localparam logic [3:0] REG_ENABLE = 4'd5;
    localparam logic [3:0] REG_COUNT  = 4'd6;
    localparam logic [3:0] REG_PSC    = 4'd7;
    localparam logic [3:0] REG_RELOAD = 4'd8;
    localparam logic [3:0] REG_CMP1   = 4'd9;
    localparam logic [3:0] REG_MOE    = 4'd13;

    // Channel output modes (bits 6:4 of a channel's mode byte)
    localparam logic [2:0] MODE_FORCE_HIGH = 3'd5;
    localparam logic [2:0] MODE_PWM1       = 3'd6;
    localparam logic [2:0] MODE_PWM2       = 3'd7;

    // Direction code for an output channel (bits 1:0 of the mode byte)
    localparam logic [1:0] DIR_OUTPUT = 2'b00;

    // Configuration port register index
    localparam logic CFG_ADV_GATING = 1'b0;

    // One input item
    typedef struct packed {
        ptmr_op_t    op;
        logic [3:0]  reg_index;
        logic [15:0] write_data;
    } ptmr_item_t;

    // One result item
    typedef struct packed {
        logic        update_flag;
        logic [3:0]  pwm_levels;
        logic [15:0] read_data;
    } ptmr_result_t;

endpackage

// ----- rtl/core/ptmr_core.sv -----
`timescale 1ns / 1ps

// Timer register file, counter and PWM level logic. The state moves on at
// the edge where item_valid is high; result shows the state after the item.
module ptmr_core
    import ptmr_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16,
    parameter int CHANNELS      = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  ptmr_item_t   item,
    input  logic         adv_gating,
    output ptmr_result_t result
);

`include "pwm_timer_peripheral_unit_assert.svh"

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONES = {COUNTER_WIDTH{1'b1}};

    // Timer state
    logic [15:0]              psc_cnt_reg,  psc_cnt_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg,      cnt_next;
    logic [15:0]              psc_pre_reg,  psc_pre_next;
    logic [15:0]              psc_act_reg,  psc_act_next;
    logic [COUNTER_WIDTH-1:0] arr_pre_reg,  arr_pre_next;
    logic [COUNTER_WIDTH-1:0] arr_act_reg,  arr_act_next;
    logic [15:0]              cmp_pre_reg  [CHANNELS];
    logic [15:0]              cmp_pre_next [CHANNELS];
    logic [15:0]              cmp_act_reg  [CHANNELS];
    logic [15:0]              cmp_act_next [CHANNELS];
    logic [1:0]               ctrl_reg,     ctrl_next;   // bit0 enable, bit1 reload preload
    logic                     uif_reg,      uif_next;
    logic [15:0]              mode_reg     [2];
    logic [15:0]              mode_next    [2];
    logic [15:0]              ccer_reg,     ccer_next;
    logic                     moe_reg,      moe_next;

    logic                     upd_evt;
    logic [15:0]              rd_data;
    logic [3:0]               levels;

    // Mode byte of a channel
    function automatic logic [7:0] chan_byte(input logic [15:0] m0, input logic [15:0] m1,
                                             input int ch);
        logic [15:0] w;
        w = (ch >= 2) ? m1 : m0;
        return (ch % 2 == 1) ? w[15:8] : w[7:0];
    endfunction

    // Next state for one item
    always_comb begin
        logic [7:0] cmp_mode;
        psc_cnt_next = psc_cnt_reg;
        cnt_next     = cnt_reg;
        psc_pre_next = psc_pre_reg;
        psc_act_next = psc_act_reg;
        arr_pre_next = arr_pre_reg;
        arr_act_next = arr_act_reg;
        cmp_pre_next = cmp_pre_reg;
        cmp_act_next = cmp_act_reg;
        ctrl_next    = ctrl_reg;
        uif_next     = uif_reg;
        mode_next    = mode_reg;
        ccer_next    = ccer_reg;
        moe_next     = moe_reg;
        upd_evt      = 1'b0;
        rd_data      = 16'd0;
        cmp_mode     = 8'd0;

        case (item.op)
            OP_TICK: begin
                if (ctrl_reg[0]) begin
                    if (psc_cnt_reg >= psc_act_reg) begin
                        psc_cnt_next = 16'd0;
                        if (cnt_reg == arr_act_reg) begin
                            cnt_next = '0;
                            upd_evt  = 1'b1;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else begin
                        psc_cnt_next = psc_cnt_reg + 16'd1;
                    end
                end
            end
            OP_WRITE: begin
                case (item.reg_index)
                    REG_CTRL:   ctrl_next = {item.write_data[7], item.write_data[0]};
                    REG_STATUS: begin
                        if (!item.write_data[0]) uif_next = 1'b0;
                    end
                    REG_EVENT: begin
                        // forced update restarts the count
                        if (item.write_data[0]) begin
                            psc_cnt_next = 16'd0;
                            cnt_next     = '0;
                            upd_evt      = 1'b1;
                        end
                    end
                    REG_MODE12: mode_next[0] = item.write_data;
                    REG_MODE34: mode_next[1] = item.write_data;
                    REG_ENABLE: ccer_next    = item.write_data;
                    REG_COUNT:  cnt_next     = COUNTER_WIDTH'(item.write_data);
                    REG_PSC:    psc_pre_next = item.write_data;
                    REG_RELOAD: begin
                        arr_pre_next = COUNTER_WIDTH'(item.write_data);
                        if (!ctrl_reg[1]) arr_act_next = COUNTER_WIDTH'(item.write_data);
                    end
                    REG_MOE:    moe_next = item.write_data[15];
                    default: begin
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            if (item.reg_index == REG_CMP1 + 4'(ch)) begin
                                cmp_pre_next[ch] = item.write_data;
                                cmp_mode = chan_byte(mode_reg[0], mode_reg[1], ch);
                                if (!cmp_mode[3])
                                    cmp_act_next[ch] = item.write_data;
                            end
                        end
                    end
                endcase
            end
            OP_READ: begin
                case (item.reg_index)
                    REG_CTRL:   rd_data = {8'd0, ctrl_reg[1], 6'd0, ctrl_reg[0]};
                    REG_STATUS: rd_data = {15'd0, uif_reg};
                    REG_MODE12: rd_data = mode_reg[0];
                    REG_MODE34: rd_data = mode_reg[1];
                    REG_ENABLE: rd_data = ccer_reg;
                    REG_COUNT:  rd_data = cnt_reg[15:0];
                    REG_PSC:    rd_data = psc_pre_reg;
                    REG_RELOAD: rd_data = arr_pre_reg[15:0];
                    REG_MOE:    rd_data = {moe_reg, 15'd0};
                    default: begin
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            if (item.reg_index == REG_CMP1 + 4'(ch))
                                rd_data = cmp_pre_reg[ch];
                        end
                    end
                endcase
            end
            default: ;
        endcase

        // update event: load active copies from preloads
        if (upd_evt) begin
            psc_act_next = psc_pre_reg;
            arr_act_next = arr_pre_reg;
            cmp_act_next = cmp_pre_reg;
            uif_next     = 1'b1;
        end
    end

    // Channel levels after the item
    always_comb begin
        logic [7:0] b;
        logic       below;
        logic       ref_lvl;
        logic       en;
        levels = 4'd0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            b       = chan_byte(mode_next[0], mode_next[1], ch);
            below   = cnt_next < COUNTER_WIDTH'(cmp_act_next[ch]);
            ref_lvl = 1'b0;
            if (b[1:0] == DIR_OUTPUT) begin
                case (b[6:4])
                    MODE_FORCE_HIGH: ref_lvl = 1'b1;
                    MODE_PWM1:       ref_lvl = below;
                    MODE_PWM2:       ref_lvl = !below;
                    default:         ref_lvl = 1'b0;
                endcase
            end
            en = ccer_next[4*ch] && !(adv_gating && !moe_next);
            levels[ch] = en && (ref_lvl ^ ccer_next[4*ch+1]);
        end
    end

    assign result.read_data   = rd_data;
    assign result.pwm_levels  = levels;
    assign result.update_flag = uif_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psc_cnt_reg <= 16'd0;
            cnt_reg     <= '0;
            psc_pre_reg <= 16'd0;
            psc_act_reg <= 16'd0;
            arr_pre_reg <= CNT_ONES;
            arr_act_reg <= CNT_ONES;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                cmp_pre_reg[ch] <= 16'd0;
                cmp_act_reg[ch] <= 16'd0;
            end
            ctrl_reg    <= 2'd0;
            uif_reg     <= 1'b0;
            mode_reg[0] <= 16'd0;
            mode_reg[1] <= 16'd0;
            ccer_reg    <= 16'd0;
            moe_reg     <= 1'b0;
        end else if (item_valid) begin
            psc_cnt_reg <= psc_cnt_next;
            cnt_reg     <= cnt_next;
            psc_pre_reg <= psc_pre_next;
            psc_act_reg <= psc_act_next;
            arr_pre_reg <= arr_pre_next;
            arr_act_reg <= arr_act_next;
            cmp_pre_reg <= cmp_pre_next;
            cmp_act_reg <= cmp_act_next;
            ctrl_reg    <= ctrl_next;
            uif_reg     <= uif_next;
            mode_reg    <= mode_next;
            ccer_reg    <= ccer_next;
            moe_reg     <= moe_next;
        end
    end

    // A tick with the counter stopped leaves the count alone
    `PTMR_ASSERT(a_stopped_hold, aclk, aresetn,
        item_valid && item.op == OP_TICK && !ctrl_reg[0] |=> $stable(cnt_reg),
        "counter moved while disabled")
    // An update event always raises the flag
    `PTMR_ASSERT(a_upd_flag, aclk, aresetn,
        item_valid && upd_evt |=> uif_reg,
        "update event did not set the flag")
    // Idle cycles leave the timer state untouched
    `PTMR_ASSERT(a_idle_hold, aclk, aresetn,
        !item_valid |=> $stable(cnt_reg) && $stable(psc_cnt_reg) && $stable(uif_reg),
        "timer state changed without an item")

endmodule

// ----- rtl/core/pwm_timer_peripheral_unit.sv -----
`timescale 1ns / 1ps

// Timer with up to four PWM channels, driven as a stream of items.
// Input channel s_*: each transfer is one item: a clock tick, a timer
// register write or a timer register read (kind in s_tuser). Output
// channel m_*: exactly one result per item, in order: the read data (zero
// unless a read), the channel levels and the update flag after the item.
// Items flow through an input register and a result register, with the timer
// state update and the level compare between them; one item is taken every
// cycle as long as the receiver takes the results without stalling.
// When the receiver stalls, the result register holds, the input register
// fills behind it and s_tready drops; nothing is lost or repeated.
// The APB port holds the gating option (register 0 at byte address 0); the user
// must write it only while no items are in flight; the block does not enforce this.
// Reset (aresetn low, synchronous) empties both stages, stops the counter,
// clears all timer registers and sets the reload values to all ones.
module pwm_timer_peripheral_unit
    import ptmr_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16,
    parameter int CHANNELS      = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] reg_index, [19:4] write_data, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] read_data, [19:16] pwm_levels,
                                   // [20] update_flag, [23:21] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "pwm_timer_peripheral_unit_assert.svh"

    logic         in_valid_reg;
    ptmr_item_t   in_item_reg;
    logic         out_valid_reg;
    ptmr_result_t out_res_reg;
    logic         adv_reg;
    logic         advance;
    ptmr_result_t core_res;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_ADV_GATING) ? {31'd0, adv_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adv_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_ADV_GATING) begin
            adv_reg <= pwdata[0];
        end
    end

    // Stage handshake: the input stage moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op         <= ptmr_op_t'(s_tuser[1:0]);
            in_item_reg.reg_index  <= s_tdata[3:0];
            in_item_reg.write_data <= s_tdata[19:4];
        end
    end

    ptmr_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .CHANNELS      (CHANNELS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item       (in_item_reg),
        .adv_gating (adv_reg),
        .result     (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.update_flag, out_res_reg.pwm_levels,
                       out_res_reg.read_data};

    // Full pipe with a stalled receiver refuses new items
    `PTMR_ASSERT(a_full_stall, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready,
        "input accepted while both stages are blocked")
    // A held item stays in the input stage
    `PTMR_ASSERT(a_in_hold, aclk, aresetn,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg),
        "stalled item dropped or changed")
    // Every processed item yields a result next cycle
    `PTMR_ASSERT(a_result_out, aclk, aresetn,
        advance |=> m_tvalid,
        "processed item produced no result")

endmodule

// ----- test/ptmr_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the timer, predicts every result from the
// accepted items and compares each result transfer with the oldest
// prediction. Also tracks the gating option from APB writes.
module ptmr_result_checker
    import ptmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] reg_index, [19:4] write_data, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [15:0] read_data, [19:16] pwm_levels,
                                   // [20] update_flag, [23:21] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_count
);

    localparam logic [2:0] ADV_GATING_ADDR = {CFG_ADV_GATING, 2'b00};
    localparam int         REPORT_LIMIT    = 10;

    // Timer state as seen from the register map
    logic [15:0] psc_count;
    logic [15:0] cnt;
    logic [15:0] psc_pre;
    logic [15:0] psc_act;
    logic [15:0] arr_pre;
    logic [15:0] arr_act;
    logic [15:0] ccr_pre [4];
    logic [15:0] ccr_act [4];
    logic [15:0] ccmr [2];
    logic [15:0] ccer;
    logic        cen;
    logic        arpe;
    logic        uif;
    logic        moe;
    logic        adv_gating;

    ptmr_result_t predicted_results [$];
    int           errors = 0;

    function automatic void reset_timer();
        psc_count  = '0;
        cnt        = '0;
        psc_pre    = '0;
        psc_act    = '0;
        arr_pre    = '1;
        arr_act    = '1;
        ccmr[0]    = '0;
        ccmr[1]    = '0;
        ccer       = '0;
        cen        = 1'b0;
        arpe       = 1'b0;
        uif        = 1'b0;
        moe        = 1'b0;
        adv_gating = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ccr_pre[i] = '0;
            ccr_act[i] = '0;
        end
    endfunction

    function automatic logic [7:0] mode_byte(int ch);
        logic [15:0] w;
        w = ccmr[ch / 2];
        return (ch % 2 != 0) ? w[15:8] : w[7:0];
    endfunction

    // Update event: shadow registers take the preload values
    function automatic void load_shadows();
        psc_act = psc_pre;
        arr_act = arr_pre;
        for (int i = 0; i < 4; i++) ccr_act[i] = ccr_pre[i];
        uif = 1'b1;
    endfunction

    function automatic logic [3:0] channel_levels();
        logic [3:0] lv;
        logic [7:0] b;
        logic       ref_lvl;
        logic       en;
        lv = '0;
        for (int ch = 0; ch < 4; ch++) begin
            b       = mode_byte(ch);
            ref_lvl = 1'b0;
            if (b[1:0] == DIR_OUTPUT) begin
                case (b[6:4])
                    MODE_FORCE_HIGH: ref_lvl = 1'b1;
                    MODE_PWM1:       ref_lvl = (cnt < ccr_act[ch]);
                    MODE_PWM2:       ref_lvl = !(cnt < ccr_act[ch]);
                    default:         ref_lvl = 1'b0;
                endcase
            end
            en = ccer[4 * ch];
            if (adv_gating && !moe) en = 1'b0;
            if (en) lv[ch] = ref_lvl ^ ccer[4 * ch + 1];
        end
        return lv;
    endfunction

    function automatic logic [15:0] read_register(logic [3:0] idx);
        case (idx)
            REG_CTRL:   return {8'h00, arpe, 6'b000000, cen};
            REG_STATUS: return {15'h0000, uif};
            REG_MODE12: return ccmr[0];
            REG_MODE34: return ccmr[1];
            REG_ENABLE: return ccer;
            REG_COUNT:  return cnt;
            REG_PSC:    return psc_pre;
            REG_RELOAD: return arr_pre;
            REG_CMP1, REG_CMP1 + 4'd1, REG_CMP1 + 4'd2, REG_CMP1 + 4'd3:
                return ccr_pre[2'(idx - REG_CMP1)];
            REG_MOE:    return {moe, 15'h0000};
            default:    return 16'h0000;
        endcase
    endfunction

    function automatic void write_register(logic [3:0] idx, logic [15:0] d);
        logic [7:0] b;
        case (idx)
            REG_CTRL: begin
                cen  = d[0];
                arpe = d[7];
            end
            REG_STATUS: begin
                if (!d[0]) uif = 1'b0;
            end
            REG_EVENT: begin
                if (d[0]) begin
                    psc_count = '0;
                    cnt       = '0;
                    load_shadows();
                end
            end
            REG_MODE12: ccmr[0] = d;
            REG_MODE34: ccmr[1] = d;
            REG_ENABLE: ccer = d;
            REG_COUNT:  cnt = d;
            REG_PSC:    psc_pre = d;
            REG_RELOAD: begin
                arr_pre = d;
                if (!arpe) arr_act = d;
            end
            REG_CMP1, REG_CMP1 + 4'd1, REG_CMP1 + 4'd2, REG_CMP1 + 4'd3: begin
                ccr_pre[2'(idx - REG_CMP1)] = d;
                b = mode_byte(idx - REG_CMP1);
                if (!b[3]) ccr_act[2'(idx - REG_CMP1)] = d;
            end
            REG_MOE: moe = d[15];
            default: ;
        endcase
    endfunction

    // One timer clock: prescaler, then counter with wrap at the reload value
    function automatic void count_tick();
        if (cen) begin
            if (psc_count >= psc_act) begin
                psc_count = '0;
                if (cnt == arr_act) begin
                    cnt = '0;
                    load_shadows();
                end else begin
                    cnt = cnt + 16'd1;
                end
            end else begin
                psc_count = psc_count + 16'd1;
            end
        end
    endfunction

    function automatic ptmr_result_t timer_step(logic [1:0] op, logic [3:0] idx,
                                                logic [15:0] d);
        ptmr_result_t res;
        res.read_data = '0;
        case (op)
            OP_TICK:  count_tick();
            OP_WRITE: write_register(idx, d);
            OP_READ:  res.read_data = read_register(idx);
            default:  ;
        endcase
        res.pwm_levels  = channel_levels();
        res.update_flag = uif;
        return res;
    endfunction

    initial reset_timer();

    // Sample both streams and the APB port on every rising edge
    always @(posedge aclk) begin
        ptmr_result_t exp_res;
        ptmr_result_t got_res;
        if (!aresetn) begin
            reset_timer();
            predicted_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADV_GATING_ADDR)
                adv_gating = pwdata[0];
            // result transfer first: it can never belong to this edge's input
            if (m_tvalid && m_tready) begin
                got_res = m_tdata[20:0];
                if (predicted_results.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result with none predicted: rd=%h lv=%h uif=%b",
                                 $time, got_res.read_data, got_res.pwm_levels,
                                 got_res.update_flag);
                end else begin
                    exp_res = predicted_results.pop_front();
                    if (got_res.read_data !== exp_res.read_data ||
                        got_res.pwm_levels !== exp_res.pwm_levels ||
                        got_res.update_flag !== exp_res.update_flag) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: mismatch rd=%h/%h lv=%h/%h uif=%b/%b (exp/got)",
                                     $time, exp_res.read_data, got_res.read_data,
                                     exp_res.pwm_levels, got_res.pwm_levels,
                                     exp_res.update_flag, got_res.update_flag);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(timer_step(s_tuser, s_tdata[3:0],
                                                       s_tdata[19:4]));
        end
        pending_count  <= predicted_results.size();
        mismatch_count <= errors;
    end

endmodule

// ----- test/tb_pwm_timer_peripheral_unit.sv -----
`timescale 1ns / 1ps

module tb_pwm_timer_peripheral_unit;
    import ptmr_pkg::*;

    localparam int          STALL_LIMIT     = 1000;
    localparam int          PHASES          = 6;
    localparam int          BODY_ITEMS      = 72;
    localparam logic [2:0]  ADV_GATING_ADDR = {CFG_ADV_GATING, 2'b00};
    localparam logic [3:0]  REG_SPARE_LO    = REG_MOE + 4'd1;
    localparam logic [3:0]  REG_SPARE_HI    = REG_MOE + 4'd2;
    localparam logic [1:0]  OP_NONE         = 2'd3;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [31:0] prdata;
    logic        pready;

    logic        idle_on = 1'b1;
    int          mismatches;
    int          pending;
    int          quiet_cycles = 0;

    always #5 aclk = ~aclk;

    pwm_timer_peripheral_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ptmr_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_pwm_timer_peripheral_unit NOT OK");
            $finish;
        end
    end

    // Result side: random stall before each result transfer while idle_on is set
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // One input transfer, preceded by a random gap while idle_on is set
    task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                             input logic [15:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, data, idx};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drain: all results in, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_gating(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADV_GATING_ADDR;
        pwdata  <= {31'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mode byte biased toward output channels in a driving mode
    function automatic logic [7:0] rand_mode_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
                0:       b[6:4] = MODE_FORCE_HIGH;
                1:       b[6:4] = MODE_PWM1;
                default: b[6:4] = MODE_PWM2;
            endcase
        end
        if ($urandom_range(0, 4) != 0) b[1:0] = DIR_OUTPUT;
        return b;
    endfunction

    initial begin
        logic [15:0] reload_val;
        logic [15:0] psc_val;
        logic        preload_on;
        int          r;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset values, preload paths, forced update, flag clear,
        // wrap at reload, count beyond reload, odd modes, unused registers
        send_item(OP_READ,  REG_CTRL,   16'h0000);
        send_item(OP_WRITE, REG_RELOAD, 16'h0003);
        send_item(OP_WRITE, REG_MODE12, 16'h7868);
        send_item(OP_WRITE, REG_MODE34, 16'h3150);
        send_item(OP_WRITE, REG_ENABLE, 16'h2131);
        send_item(OP_WRITE, REG_CMP1,   16'h0002);
        send_item(OP_WRITE, REG_CMP1 + 4'd1, 16'hFFFF);
        send_item(OP_WRITE, REG_EVENT,  16'h0000);
        send_item(OP_WRITE, REG_EVENT,  16'h0001);
        send_item(OP_WRITE, REG_STATUS, 16'h0001);
        send_item(OP_WRITE, REG_CTRL,   16'h0081);
        repeat (5) send_item(OP_TICK, REG_CTRL, 16'h0000);
        send_item(OP_WRITE, REG_STATUS, 16'hFFFE);
        send_item(OP_WRITE, REG_RELOAD, 16'h0001);
        send_item(OP_WRITE, REG_COUNT,  16'hFFFF);
        send_item(OP_TICK,  REG_COUNT,  16'hFFFF);
        send_item(OP_WRITE, REG_CMP1 + 4'd2, 16'h8000);
        send_item(OP_WRITE, REG_SPARE_LO, 16'hFFFF);
        send_item(OP_READ,  REG_SPARE_HI, 16'hFFFF);
        send_item(OP_NONE,  REG_SPARE_HI, 16'hFFFF);
        send_item(OP_WRITE, REG_MOE,    16'h8000);
        send_item(OP_READ,  REG_MOE,    16'h0000);

        // Random phases: set the timer up, then mostly ticks
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            write_gating((phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
            idle_on <= (phase % 3 != 2);

            r = $urandom_range(0, 9);
            psc_val = (r == 0) ? 16'hFFFF : (r == 1) ? 16'($urandom) : 16'($urandom_range(0, 2));
            r = $urandom_range(0, 15);
            reload_val = (r == 0) ? 16'hFFFF : (r == 1) ? 16'($urandom_range(0, 2))
                                              : 16'($urandom_range(3, 24));
            preload_on = 1'($urandom_range(0, 1));

            send_item(OP_WRITE, REG_CTRL, {8'($urandom), preload_on, 6'($urandom), 1'b0});
            send_item(OP_WRITE, REG_PSC, psc_val);
            send_item(OP_WRITE, REG_RELOAD, reload_val);
            send_item(OP_WRITE, REG_MODE12, {rand_mode_byte(), rand_mode_byte()});
            send_item(OP_WRITE, REG_MODE34, {rand_mode_byte(), rand_mode_byte()});
            for (int ch = 0; ch < 4; ch++)
                send_item(OP_WRITE, REG_CMP1 + 4'(ch),
                          16'($urandom_range(0, int'(reload_val) + 3)));
            send_item(OP_WRITE, REG_ENABLE, 16'($urandom));
            send_item(OP_WRITE, REG_MOE, 16'($urandom));
            send_item(OP_WRITE, REG_EVENT, 16'h0001);
            send_item(OP_WRITE, REG_CTRL, {8'($urandom), preload_on, 6'($urandom), 1'b1});

            for (int n = 0; n < BODY_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_item(OP_TICK, 4'($urandom), 16'($urandom));
                end else if (r < 80) begin
                    send_item(OP_READ, 4'($urandom_range(0, 15)), 16'($urandom));
                end else if (r < 92) begin
                    case ($urandom_range(0, 7))
                        0: send_item(OP_WRITE, REG_STATUS, 16'($urandom));
                        1: send_item(OP_WRITE, REG_EVENT, 16'($urandom));
                        2: send_item(OP_WRITE, REG_CMP1 + 4'($urandom_range(0, 3)),
                                     16'($urandom_range(0, int'(reload_val) + 3)));
                        3: send_item(OP_WRITE, REG_RELOAD, 16'($urandom_range(0, 24)));
                        4: send_item(OP_WRITE, REG_ENABLE, 16'($urandom));
                        5: send_item(OP_WRITE, REG_MOE, 16'($urandom));
                        6: send_item(OP_WRITE, REG_COUNT, 16'($urandom_range(0, 30)));
                        default: send_item(OP_WRITE, ($urandom_range(0, 1) != 0) ?
                                           REG_MODE12 : REG_MODE34,
                                           {rand_mode_byte(), rand_mode_byte()});
                    endcase
                end else begin
                    // noise: any kind, any register, any data
                    send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              16'($urandom));
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && pending == 0) begin
            $display("tb_pwm_timer_peripheral_unit OK");
        end else begin
            $display("tb_pwm_timer_peripheral_unit NOT OK");
        end
        $finish;
    end

endmodule
